// ----- hdl/rgbw_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the RGBW LED driver.
package rgbw_pkg;

    localparam int MAX_LEDS     = 64;
    localparam int LED_W        = $clog2(MAX_LEDS);
    localparam int LEDS_W       = 7;
    localparam int BITS_PER_LED = 32;
    localparam int BIT_W        = $clog2(BITS_PER_LED);
    localparam int WORD_W       = 32;
    localparam int TICK_W       = 8;
    localparam int COLOR_W      = 8;
    localparam int INDEX_W      = 6;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = TICK_W'(8);
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = TICK_W'(8);
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = TICK_W'(4);
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = TICK_W'(10);
    localparam logic [LEDS_W-1:0] LEDS_RST      = LEDS_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_ONE = 2'd0,
        CMD_WRITE_ALL = 2'd1,
        CMD_START     = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ZERO_LOW  = 3'd3,
        CFG_LEDS      = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIGH,
        ST_LOW
    } state_t;

    typedef struct packed {
        logic write_one;
        logic write_all;
        logic start;
        logic count;
        logic to_low;
        logic next_bit;
        logic next_led;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_last;
        logic bit_last;
        logic led_last;
    } dp_status_t;

endpackage

// ----- hdl/rgbw_dp.sv -----
// Datapath: configuration registers, colour store, shift word and line timing counters.
module rgbw_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rgbw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [rgbw_pkg::INDEX_W-1:0]    index,
    input  logic [rgbw_pkg::COLOR_W-1:0]    green,
    input  logic [rgbw_pkg::COLOR_W-1:0]    red,
    input  logic [rgbw_pkg::COLOR_W-1:0]    blue,
    input  logic [rgbw_pkg::COLOR_W-1:0]    white,
    input  rgbw_pkg::dp_cmd_t             cmd,
    output rgbw_pkg::dp_status_t          status
);
    import rgbw_pkg::*;

    logic [TICK_W-1:0]  one_high_reg, one_low_reg, zero_high_reg, zero_low_reg;
    logic [LEDS_W-1:0]  leds_reg;
    logic [WORD_W-1:0]  mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] valid_reg;
    logic [WORD_W-1:0]  fill_reg;
    logic [WORD_W-1:0]  led0_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_valid_reg;
    logic [WORD_W-1:0]  shift_reg, shift_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [TICK_W-1:0]  phase_reg, phase_next;

    logic [WORD_W-1:0]  colour;
    logic [WORD_W-1:0]  next_word;
    logic [LED_W-1:0]   wr_addr;
    logic               index_ok;
    logic [LED_W-1:0]   rd_addr;
    logic               rd_en;
    logic [LEDS_W-1:0]  leds_eff;
    logic [LEDS_W-1:0]  led_plus;
    logic               high_sel;
    logic [TICK_W-1:0]  high_ticks;
    logic [TICK_W-1:0]  low_ticks;

    assign colour    = {green, red, blue, white};
    assign next_word = rd_valid_reg ? rd_data_reg : fill_reg;
    assign wr_addr   = index[LED_W-1:0];
    assign index_ok  = 32'(index) < MAX_LEDS;
    assign rd_en     = cmd.start | cmd.next_led;
    assign rd_addr   = cmd.start ? LED_W'(1) : LED_W'(led_reg + LED_W'(2));

    always_comb
    begin
        if (leds_reg == '0)
            leds_eff = LEDS_W'(1);
        else if (leds_reg > LEDS_W'(MAX_LEDS))
            leds_eff = LEDS_W'(MAX_LEDS);
        else
            leds_eff = leds_reg;
    end

    assign led_plus = LEDS_W'(led_reg) + LEDS_W'(1);

    assign status.phase_last = phase_reg <= TICK_W'(1);
    assign status.bit_last   = bit_reg == BIT_W'(BITS_PER_LED - 1);
    assign status.led_last   = led_plus >= leds_eff;

    always_comb
    begin
        if (cmd.start)
            high_sel = led0_reg[WORD_W-1];
        else if (cmd.next_led)
            high_sel = next_word[WORD_W-1];
        else
            high_sel = shift_reg[WORD_W-2];
        high_ticks = high_sel ? one_high_reg : zero_high_reg;
        if (high_ticks == '0)
            high_ticks = TICK_W'(1);
        low_ticks = shift_reg[WORD_W-1] ? one_low_reg : zero_low_reg;
        if (low_ticks == '0)
            low_ticks = TICK_W'(1);
    end

    always_comb
    begin
        shift_next = shift_reg;
        led_next   = led_reg;
        bit_next   = bit_reg;
        phase_next = phase_reg;
        if (cmd.start)
        begin
            shift_next = led0_reg;
            led_next   = '0;
            bit_next   = '0;
            phase_next = high_ticks;
        end
        else if (cmd.count)
        begin
            phase_next = phase_reg - TICK_W'(1);
        end
        else if (cmd.to_low)
        begin
            phase_next = low_ticks;
        end
        else if (cmd.next_bit)
        begin
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            bit_next   = bit_reg + BIT_W'(1);
            phase_next = high_ticks;
        end
        else if (cmd.next_led)
        begin
            shift_next = next_word;
            led_next   = led_reg + LED_W'(1);
            bit_next   = '0;
            phase_next = high_ticks;
        end
        else if (cmd.finish)
        begin
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            led_next   = '0;
            bit_next   = '0;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= ONE_HIGH_RST;
            one_low_reg   <= ONE_LOW_RST;
            zero_high_reg <= ZERO_HIGH_RST;
            zero_low_reg  <= ZERO_LOW_RST;
            leds_reg      <= LEDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ONE_HIGH:  one_high_reg  <= cfg_data;
                CFG_ONE_LOW:   one_low_reg   <= cfg_data;
                CFG_ZERO_HIGH: zero_high_reg <= cfg_data;
                CFG_ZERO_LOW:  zero_low_reg  <= cfg_data;
                CFG_LEDS:      leds_reg      <= cfg_data[LEDS_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            led0_reg  <= '0;
        end
        else if (cmd.write_all)
        begin
            valid_reg <= '0;
            fill_reg  <= colour;
            led0_reg  <= colour;
        end
        else if (cmd.write_one && index_ok)
        begin
            valid_reg[wr_addr] <= 1'b1;
            if (wr_addr == '0)
                led0_reg <= colour;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_one && index_ok)
            mem[wr_addr] <= colour;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            shift_reg    <= '0;
            led_reg      <= '0;
            bit_reg      <= '0;
            phase_reg    <= '0;
        end
        else
        begin
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
            shift_reg <= shift_next;
            led_reg   <= led_next;
            bit_reg   <= bit_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- hdl/rgbw_ctrl.sv -----
// Controller: frame state machine that sequences the datapath per accepted transaction.
module rgbw_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [rgbw_pkg::CMD_W-1:0] command,
    input  rgbw_pkg::dp_status_t       status,
    output rgbw_pkg::dp_cmd_t          cmd,
    output logic                       line_next,
    output logic                       busy_next,
    output logic                       done_next
);
    import rgbw_pkg::*;

    state_t state_reg, state_next;
    cmd_t   op;
    logic   tick;

    assign op   = cmd_t'(command);
    assign tick = accept && (op == CMD_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        CMD_WRITE_ONE: cmd.write_one = 1'b1;
                        CMD_WRITE_ALL: cmd.write_all = 1'b1;
                        CMD_START:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_HIGH;
                        end
                        CMD_TICK:      ;
                        default:       ;
                    endcase
                end
            end
            ST_HIGH:
            begin
                if (tick)
                begin
                    if (status.phase_last)
                    begin
                        cmd.to_low = 1'b1;
                        state_next = ST_LOW;
                    end
                    else
                        cmd.count = 1'b1;
                end
            end
            ST_LOW:
            begin
                if (tick)
                begin
                    if (!status.phase_last)
                        cmd.count = 1'b1;
                    else if (!status.bit_last)
                    begin
                        cmd.next_bit = 1'b1;
                        state_next   = ST_HIGH;
                    end
                    else if (!status.led_last)
                    begin
                        cmd.next_led = 1'b1;
                        state_next   = ST_HIGH;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        line_next = state_next == ST_HIGH;
        busy_next = state_next != ST_IDLE;
    end

    a_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next != ST_IDLE) |-> (accept && op == CMD_START))
        else $error("frame started without a start transaction");

    a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |-> (state_reg == ST_LOW && status.phase_last && status.bit_last
                       && status.led_last && tick))
        else $error("frame_done raised before the last bit ended");

    a_phase_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_next != state_reg) |-> tick)
        else $error("line phase changed without a tick");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath action in a cycle");

endmodule

// ----- hdl/rgbw_led_strip_driver.sv -----
// Top level of the RGBW LED strip driver: handshake, result register and unit wiring.
//
// Input channel (in_valid/in_stall) carries one command per transaction: write one
// LED, write all LEDs, start a frame, or a tick that advances line time. Every
// accepted transaction produces exactly one result on the output channel
// (out_valid/out_stall): line level, busy flag and frame_done after that command.
// out_valid rises in the cycle after acceptance; one transaction is taken per
// cycle, write-all included, as long as results are drained. The result register
// lets a new transaction in during the cycle its predecessor is taken; while
// out_stall holds a waiting result, in_stall is raised and nothing is lost.
// Next-LED words are prefetched from the colour store one read ahead, so ticks
// are never held off inside a frame.
// Configuration (cfg_we, cfg_index, cfg_data) must be written by the user only while idle;
// the block does not enforce this. Index 0..4 select one_high, one_low, zero_high,
// zero_low ticks and leds_in_use. Reset (rst_n low) makes the store read as zero,
// loads default timing and ends any frame; the store needs no clearing pass after reset.
module rgbw_led_strip_driver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rgbw_pkg::CMD_W-1:0]      command,
    input  logic [rgbw_pkg::INDEX_W-1:0]    index,
    input  logic [rgbw_pkg::COLOR_W-1:0]    green,
    input  logic [rgbw_pkg::COLOR_W-1:0]    red,
    input  logic [rgbw_pkg::COLOR_W-1:0]    blue,
    input  logic [rgbw_pkg::COLOR_W-1:0]    white,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            line_level,
    output logic                            busy_res,
    output logic                            frame_done,
    input  logic                            cfg_we,
    input  logic [rgbw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rgbw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       accept;
    logic       line_next, busy_next, done_next;
    logic       out_valid_reg;
    logic       line_reg, busy_reg, done_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    rgbw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .status    (status),
        .cmd       (cmd),
        .line_next (line_next),
        .busy_next (busy_next),
        .done_next (done_next)
    );

    rgbw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .index     (index),
        .green     (green),
        .red       (red),
        .blue      (blue),
        .white     (white),
        .cmd       (cmd),
        .status    (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg <= line_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = line_reg;
    assign busy_res   = busy_reg;
    assign frame_done = done_reg;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with no result pending");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_line_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_reg) |-> busy_reg)
        else $error("line high outside a frame");

endmodule
